// ===== sv/vps_pkg.sv =====
package vps_pkg;

  // field and register widths
  localparam int ENC_W      = 32;
  localparam int SP_W       = 16;
  localparam int VEL_W      = ENC_W + 1;
  localparam int ERR_W      = 16;
  localparam int DERR_W     = ERR_W + 1;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 15;
  localparam int INT_W      = 32;
  localparam int DRIVE_W    = 8;

  // shared multiplier
  localparam int MUL_A_W    = VEL_W + 1;
  localparam int MUL_B_W    = GAIN_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  // accumulator and shared divider
  localparam int QUO_W      = 53;
  localparam int DIV_W      = QUO_W - 1;
  localparam int DIV_STEP   = 4;
  localparam int DIV_ITER   = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_ITER + 1);

  // control constants
  localparam int DRIVE_MAX       = 127;
  localparam int SPEED_THRESHOLD = 10;

  // stream and configuration port widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VELOCITY_LIMIT = 3'd0,
    REG_KP_FAST        = 3'd1,
    REG_KP_SLOW        = 3'd2,
    REG_KD_GAIN        = 3'd3,
    REG_KI_GAIN        = 3'd4,
    REG_GAIN_DIVISOR   = 3'd5,
    REG_TORQUE_LIMIT   = 3'd6,
    REG_BEMF_GAIN      = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_D,
    ST_MUL_I,
    ST_MUL_B,
    ST_DIV_N,
    ST_WAIT_N,
    ST_DIV_B,
    ST_WAIT_B,
    ST_SAT,
    ST_FIN
  } state_t;

endpackage

// ===== sv/velocity_pid_servo_unit.sv =====
// Velocity PID servo: each item on the slave stream is one control tick carrying an
// absolute encoder count, a velocity setpoint and a direction bit; the block answers
// with one offset-binary drive byte on the master stream (127 is stop, range 0..254).
// Velocity is the encoder delta from the previous tick, the setpoint is clamped to
// velocity_limit, and P (gain picked by speed against a threshold of 10), D and I
// terms are summed exactly, divided by gain_divisor with truncation toward zero,
// clamped to torque_limit, then back-EMF compensation (velocity * bemf_gain / divisor)
// is added and the result saturated to +-127. The integrator only accumulates while
// the drive is not at full scale. From accept until s_tready returns, an item passes
// through ST_VEL and ST_ERR for setup, ST_MUL_P to ST_MUL_B on the shared 34x16
// multiplier, two passes through the shared radix-16 divider (start, 13 iterations,
// finish and the done handoff), which dominate, then ST_SAT for saturation and ST_FIN
// for handoff, which stretches while the previous drive byte still waits. s_tready
// is high only while the sequencer is idle; a finished
// result sits in the output register, so the next item may be taken while the
// previous drive byte still waits for m_tready. Configuration writes are accepted
// every cycle and should only be issued while the block is idle; a gain_divisor of
// zero is treated as one.
module velocity_pid_servo_unit
  import vps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [31:0] encoder_count, [47:32] velocity_setpoint, [48] direction_reverse, rest zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,

  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [7:0] drive_output
  output logic [OUT_TDATA_W-1:0] m_tdata,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic signed [VEL_W-1:0]   VEL_THR      = VEL_W'(SPEED_THRESHOLD);
  localparam logic signed [DRIVE_W-1:0] DRIVE_LIM    = DRIVE_W'(DRIVE_MAX);
  localparam logic [DRIVE_W-1:0]        DRIVE_OFFSET = DRIVE_W'(DRIVE_MAX);

  // configuration registers
  logic [LIM_W-1:0]         velocity_limit;
  logic signed [GAIN_W-1:0] kp_fast;
  logic signed [GAIN_W-1:0] kp_slow;
  logic signed [GAIN_W-1:0] kd_gain;
  logic signed [GAIN_W-1:0] ki_gain;
  logic [LIM_W-1:0]         gain_divisor;
  logic [LIM_W-1:0]         torque_limit;
  logic signed [GAIN_W-1:0] bemf_gain;

  // loop state carried between ticks
  logic signed [ENC_W-1:0]  prev_enc;
  logic signed [ERR_W-1:0]  prev_err;
  logic signed [INT_W-1:0]  integral;

  // per-tick working registers
  logic signed [ENC_W-1:0]   enc;
  logic signed [SP_W-1:0]    sp;
  logic                      rev;
  logic signed [VEL_W-1:0]   vel;
  logic signed [SP_W-1:0]    spc;
  logic signed [ERR_W-1:0]   err;
  logic signed [GAIN_W-1:0]  kp;
  logic signed [DERR_W-1:0]  derr;
  logic signed [QUO_W-1:0]   acc;
  logic signed [PROD_W-1:0]  bemf_prod;
  logic signed [ERR_W-1:0]   tq;
  logic signed [QUO_W-1:0]   sum;
  logic signed [DRIVE_W-1:0] drive;

  state_t state;
  state_t state_next;

  // shared units
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      div_start;
  logic signed [QUO_W-1:0]   div_dividend;
  logic [LIM_W-1:0]          div_divisor;
  logic                      div_done;
  logic signed [QUO_W-1:0]   quotient;

  // combinational helpers
  logic                      in_fire;
  logic                      out_free;
  logic                      fin_fire;
  logic signed [SP_W:0]      sp_x;
  logic signed [SP_W:0]      vlim_x;
  logic signed [SP_W-1:0]    spc_val;
  logic signed [VEL_W:0]     ediff;
  logic signed [ERR_W-1:0]   err_val;
  logic signed [QUO_W-1:0]   tlim_x;
  logic signed [ERR_W-1:0]   tq_val;
  logic signed [DRIVE_W-1:0] drive_val;
  logic signed [INT_W:0]     isum;
  logic signed [INT_W-1:0]   integral_next;
  logic [DRIVE_W-1:0]        drive_u;

  assign cfg_ready   = 1'b1;
  assign in_fire     = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign fin_fire    = (state == ST_FIN) && out_free;
  assign div_divisor = (gain_divisor == '0) ? LIM_W'(1) : gain_divisor;
  assign drive_u     = drive;

  vps_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  vps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = acc;
    mul_a        = '0;
    mul_b        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_VEL;
        end
      end
      ST_VEL:   state_next = ST_ERR;
      ST_ERR:   state_next = ST_MUL_P;
      ST_MUL_P: begin
        mul_a      = MUL_A_W'(err);
        mul_b      = kp;
        state_next = ST_MUL_D;
      end
      ST_MUL_D: begin
        mul_a      = MUL_A_W'(derr);
        mul_b      = kd_gain;
        state_next = ST_MUL_I;
      end
      ST_MUL_I: begin
        mul_a      = MUL_A_W'(integral);
        mul_b      = ki_gain;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        mul_a      = MUL_A_W'(vel);
        mul_b      = bemf_gain;
        state_next = ST_DIV_N;
      end
      ST_DIV_N: begin
        div_start  = 1'b1;
        state_next = ST_WAIT_N;
      end
      ST_WAIT_N: begin
        if (div_done) begin
          state_next = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        div_start    = 1'b1;
        div_dividend = QUO_W'(bemf_prod);
        state_next   = ST_WAIT_B;
      end
      ST_WAIT_B: begin
        if (div_done) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT:   state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // clamps and saturations
  always_comb begin
    sp_x   = (SP_W+1)'(sp);
    vlim_x = $signed({2'b00, velocity_limit});
    if (sp_x > vlim_x) begin
      spc_val = SP_W'(vlim_x);
    end else if (sp_x < -vlim_x) begin
      spc_val = SP_W'(-vlim_x);
    end else begin
      spc_val = sp;
    end

    // velocity error saturates to 16 bits
    ediff = (VEL_W+1)'(spc) - (VEL_W+1)'(vel);
    if (ediff > (VEL_W+1)'(32767)) begin
      err_val = 16'sh7FFF;
    end else if (ediff < -(VEL_W+1)'(32768)) begin
      err_val = 16'sh8000;
    end else begin
      err_val = ediff[ERR_W-1:0];
    end

    // torque clamp on the PID quotient
    tlim_x = $signed({{(QUO_W-LIM_W){1'b0}}, torque_limit});
    if (quotient > tlim_x) begin
      tq_val = ERR_W'(tlim_x);
    end else if (quotient < -tlim_x) begin
      tq_val = ERR_W'(-tlim_x);
    end else begin
      tq_val = quotient[ERR_W-1:0];
    end

    // final drive saturation
    if (sum > QUO_W'(DRIVE_LIM)) begin
      drive_val = DRIVE_LIM;
    end else if (sum < -QUO_W'(DRIVE_LIM)) begin
      drive_val = -DRIVE_LIM;
    end else begin
      drive_val = sum[DRIVE_W-1:0];
    end

    // integrator saturates to 32 bits
    isum = (INT_W+1)'(integral) + (INT_W+1)'(err);
    if (isum > (INT_W+1)'(33'sh0_7FFF_FFFF)) begin
      integral_next = 32'sh7FFF_FFFF;
    end else if (isum < (INT_W+1)'(33'sh1_8000_0000)) begin
      integral_next = 32'sh8000_0000;
    end else begin
      integral_next = isum[INT_W-1:0];
    end
  end

  // per-tick datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          enc <= s_tdata[31:0];
          sp  <= s_tdata[47:32];
          rev <= s_tdata[48];
        end
      end
      ST_VEL: begin
        vel <= VEL_W'(enc) - VEL_W'(prev_enc);
        spc <= spc_val;
      end
      ST_ERR: begin
        err <= err_val;
        kp  <= (vel > VEL_THR || vel < -VEL_THR) ? kp_fast : kp_slow;
      end
      ST_MUL_P: derr <= DERR_W'(err) - DERR_W'(prev_err);
      ST_MUL_D: acc  <= QUO_W'(prod);
      ST_MUL_I: acc  <= acc + QUO_W'(prod);
      ST_MUL_B: acc  <= acc + QUO_W'(prod);
      ST_DIV_N: bemf_prod <= prod;
      ST_WAIT_N: begin
        if (div_done) begin
          tq <= tq_val;
        end
      end
      ST_WAIT_B: begin
        if (div_done) begin
          sum <= QUO_W'(tq) + quotient;
        end
      end
      ST_SAT:   drive <= drive_val;
      default: begin
      end
    endcase
  end

  // loop state, updated once per tick as the result is handed off
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_enc <= '0;
      prev_err <= '0;
      integral <= '0;
    end else if (fin_fire) begin
      prev_enc <= enc;
      prev_err <= err;
      if (drive != DRIVE_LIM && drive != -DRIVE_LIM) begin
        integral <= integral_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      m_tdata <= rev ? (DRIVE_OFFSET - drive_u) : (DRIVE_OFFSET + drive_u);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_limit <= 15'h7FFF;
      kp_fast        <= '0;
      kp_slow        <= '0;
      kd_gain        <= '0;
      ki_gain        <= '0;
      gain_divisor   <= 15'd1;
      torque_limit   <= 15'd127;
      bemf_gain      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VELOCITY_LIMIT: velocity_limit <= cfg_data[LIM_W-1:0];
        REG_KP_FAST:        kp_fast        <= cfg_data;
        REG_KP_SLOW:        kp_slow        <= cfg_data;
        REG_KD_GAIN:        kd_gain        <= cfg_data;
        REG_KI_GAIN:        ki_gain        <= cfg_data;
        REG_GAIN_DIVISOR:   gain_divisor   <= cfg_data[LIM_W-1:0];
        REG_TORQUE_LIMIT:   torque_limit   <= cfg_data[LIM_W-1:0];
        REG_BEMF_GAIN:      bemf_gain      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // drive byte never leaves 0..254
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata != 8'hFF)
    else $error("drive output out of range");

  // divider only finishes while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_WAIT_N || state == ST_WAIT_B))
    else $error("divider done outside a wait state");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("item accepted while busy");

  // integrator only moves when a result is handed off
  a_integral_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FIN) |=> $stable(integral))
    else $error("integral changed outside result handoff");
`endif

endmodule

// ===== sv/vps_mul.sv =====
module vps_mul
  import vps_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod
);

  // registered signed product, exact width
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== sv/vps_div.sv =====
module vps_div
  import vps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [QUO_W-1:0] dividend,
  input  logic [LIM_W-1:0]        divisor,
  output logic                    done,
  output logic signed [QUO_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     mag;
  logic [DIV_W-1:0]     mag_next;
  logic [LIM_W-1:0]     rem;
  logic [LIM_W-1:0]     rem_next;
  logic [LIM_W-1:0]     dsr;
  logic                 neg;
  logic [QUO_W-1:0]     dvd_abs;
  logic [LIM_W:0]       trial;
  logic [LIM_W-1:0]     r;
  logic [DIV_W-1:0]     m;
  logic [QUO_W-1:0]     mag_ext;

  assign dvd_abs = dividend[QUO_W-1] ? QUO_W'(-dividend) : QUO_W'(dividend);
  assign mag_ext = {1'b0, mag};

  // four restoring steps per cycle, quotient bits shift into mag
  always_comb begin
    r     = rem;
    m     = mag;
    trial = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {r, m[DIV_W-1]};
      m     = {m[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial = trial - {1'b0, dsr};
        m[0]  = 1'b1;
      end
      r = trial[LIM_W-1:0];
    end
    rem_next = r;
    mag_next = m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_ITER);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mag <= dvd_abs[DIV_W-1:0];
      rem <= '0;
      dsr <= divisor;
      neg <= dividend[QUO_W-1];
    end else if (busy) begin
      if (cnt != '0) begin
        mag <= mag_next;
        rem <= rem_next;
      end else begin
        quotient <= neg ? -$signed(mag_ext) : $signed(mag_ext);
      end
    end
  end

endmodule

// ===== bench/servo_drive_checker.sv =====
`timescale 1ns / 100ps

module servo_drive_checker
  import vps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending_count
);

  localparam longint ERR_MIN = -(64'sd1 <<< (ERR_W - 1));
  localparam longint ERR_MAX = (64'sd1 <<< (ERR_W - 1)) - 1;
  localparam longint INT_MIN = -(64'sd1 <<< (INT_W - 1));
  localparam longint INT_MAX = (64'sd1 <<< (INT_W - 1)) - 1;

  // register copy
  logic [LIM_W-1:0]         vel_limit;
  logic [LIM_W-1:0]         gain_div;
  logic [LIM_W-1:0]         torque_lim;
  logic signed [GAIN_W-1:0] kp_fast;
  logic signed [GAIN_W-1:0] kp_slow;
  logic signed [GAIN_W-1:0] kd_gain;
  logic signed [GAIN_W-1:0] ki_gain;
  logic signed [GAIN_W-1:0] bemf_gain;

  // loop state
  logic signed [ENC_W-1:0] last_enc;
  logic signed [ERR_W-1:0] last_err;
  logic signed [INT_W-1:0] integ_sum;

  logic [DRIVE_W-1:0] drive_queue[$];

  function automatic longint limit_to(input longint x, input longint lo, input longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // one control tick: returns the drive byte and advances the loop state
  function automatic logic [DRIVE_W-1:0] next_drive(input logic [IN_TDATA_W-1:0] tick);
    longint enc, sp, vel, err, kp, kd, ki, kb, integ, num, drv, div, torque, lim;
    logic   rev;
    enc    = $signed(tick[ENC_W-1:0]);
    sp     = $signed(tick[ENC_W+SP_W-1:ENC_W]);
    rev    = tick[ENC_W+SP_W];
    div    = (gain_div == '0) ? 64'sd1 : longint'(gain_div);
    lim    = longint'(vel_limit);
    torque = longint'(torque_lim);
    kd     = kd_gain;
    ki     = ki_gain;
    kb     = bemf_gain;
    integ  = integ_sum;

    sp  = limit_to(sp, -lim, lim);
    vel = enc - longint'(last_enc);
    err = limit_to(sp - vel, ERR_MIN, ERR_MAX);
    if ((vel < 0 ? -vel : vel) > SPEED_THRESHOLD)
      kp = kp_fast;
    else
      kp = kp_slow;

    num = err * kp + (err - longint'(last_err)) * kd + integ * ki;
    drv = limit_to(num / div, -torque, torque);
    drv = drv + (vel * kb) / div;
    drv = limit_to(drv, -DRIVE_MAX, DRIVE_MAX);

    // integrator frozen at full scale
    if ((drv < 0 ? -drv : drv) < DRIVE_MAX)
      integ_sum = INT_W'(limit_to(integ + err, INT_MIN, INT_MAX));
    last_err = ERR_W'(err);
    last_enc = tick[ENC_W-1:0];

    if (rev)
      drv = -drv;
    return DRIVE_W'(drv + DRIVE_MAX);
  endfunction

  always @(posedge clk) begin
    logic [DRIVE_W-1:0] want;
    if (rst) begin
      vel_limit  = 15'd32767;
      kp_fast    = '0;
      kp_slow    = '0;
      kd_gain    = '0;
      ki_gain    = '0;
      gain_div   = 15'd1;
      torque_lim = 15'd127;
      bemf_gain  = '0;
      last_enc   = '0;
      last_err   = '0;
      integ_sum  = '0;
      drive_queue.delete();
      fail_count    = 0;
      pending_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_VELOCITY_LIMIT: vel_limit  = cfg_data[LIM_W-1:0];
          REG_KP_FAST:        kp_fast    = cfg_data;
          REG_KP_SLOW:        kp_slow    = cfg_data;
          REG_KD_GAIN:        kd_gain    = cfg_data;
          REG_KI_GAIN:        ki_gain    = cfg_data;
          REG_GAIN_DIVISOR:   gain_div   = cfg_data[LIM_W-1:0];
          REG_TORQUE_LIMIT:   torque_lim = cfg_data[LIM_W-1:0];
          REG_BEMF_GAIN:      bemf_gain  = cfg_data;
          default: ;
        endcase
      end
      // outputs first so a tick taken at this edge cannot pair with its own result
      if (m_tvalid && m_tready) begin
        if (drive_queue.size() == 0) begin
          $display("%0t: unexpected drive item, expected none, actual %0d", $time, m_tdata);
          fail_count++;
        end else begin
          want = drive_queue.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: drive_output mismatch, expected %0d, actual %0d",
                     $time, want, m_tdata);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        drive_queue.push_back(next_drive(s_tdata));
      pending_count = drive_queue.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
  import vps_pkg::*;
();

  // receiver hold-off used to back the block up
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 135;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  // [31:0] encoder_count, [47:32] velocity_setpoint, [48] direction_reverse, rest zero
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  // [7:0] drive_output
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int          fail_count;
  int          pending_count;
  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;
  logic [31:0] last_enc_sent = '0;

  always #2 clk = ~clk;

  velocity_pid_servo_unit dut (.*);

  servo_drive_checker u_checker (.*);

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    bit hold_seen;
    int cnt;
    hold_seen = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        // long stall so the output register and then the input back up
        hold_seen = hold_req;
        m_tready  = 1'b0;
        cnt = 0;
        while (cnt < HOLD_CYCLES) begin
          @(negedge clk);
          cnt++;
        end
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  // one register write, called at a falling edge, returns at a falling edge
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // write all eight registers in index order
  task automatic program_gains(input logic [CFG_DATA_W-1:0] regs[8]);
    for (int i = 0; i < 8; i++)
      write_reg(cfg_reg_t'(i), regs[i]);
  endtask

  // one control tick; valid stays high into the next tick unless a gap is drawn
  task automatic send_tick(input logic [31:0] enc, input logic [15:0] sp, input logic rev);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = IN_TDATA_W'({rev, sp, enc});
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    @(negedge clk);
    last_enc_sent = enc;
  endtask

  // stop offering and wait until every drive byte has come back
  task automatic wait_drained;
    s_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] regs[8];
    logic [31:0] enc;
    logic [15:0] sp;
    int sel;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: moderate gains, full setpoint range
    regs = '{16'd32767, 16'd300, -16'sd200, 16'd50, 16'd3, 16'd100, 16'd32767, 16'd7};
    program_gains(regs);
    send_tick(32'd0, 16'd0, 1'b0);
    send_tick(32'd5, 16'h7FFF, 1'b0);
    send_tick(32'd20, 16'h8000, 1'b1);
    // speed threshold boundary: |v| of 10 picks kp_slow, 11 picks kp_fast
    send_tick(32'd30, 16'd10, 1'b0);
    send_tick(32'd41, 16'd10, 1'b1);
    send_tick(32'd30, -16'sd10, 1'b0);
    send_tick(32'd20, -16'sd10, 1'b1);
    // encoder wrap: velocity must be taken on 33 bits, error saturates
    send_tick(32'h7FFF_FFFF, 16'd0, 1'b0);
    send_tick(32'h8000_0000, 16'd100, 1'b0);
    send_tick(32'h8000_0000, 16'd100, 1'b1);
    send_tick(32'h8000_0005, -16'sd5, 1'b1);
    send_tick(32'h7FFF_FFFF, 16'h7FFF, 1'b0);
    send_tick(32'hFFFF_FFFF, 16'h8000, 1'b0);
    send_tick(32'd0, 16'd0, 1'b1);
    wait_drained;

    // directed: zero limits, zero divisor (acts as one), extreme gains
    regs = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF};
    program_gains(regs);
    send_tick(32'd3, 16'h7FFF, 1'b0);
    send_tick(32'hFFFF_FFF0, 16'h8000, 1'b1);
    send_tick(32'hFFFF_FFF0, 16'd1, 1'b0);
    send_tick(32'h0000_0100, 16'hFFFF, 1'b1);
    wait_drained;

    // directed: small setpoint limit, odd divisor for truncation of negatives
    regs = '{16'd50, -16'sd900, 16'd700, -16'sd300, 16'd11, 16'd7, 16'd60, -16'sd25};
    program_gains(regs);
    send_tick(32'h0000_0104, 16'd500, 1'b0);
    send_tick(32'h0000_00F0, -16'sd500, 1'b0);
    send_tick(32'h0000_00F3, 16'd49, 1'b1);
    send_tick(32'h0000_00F3, -16'sd51, 1'b0);
    send_tick(32'h0000_00E0, 16'd0, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained;
      case (ph)
        0: regs = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0001, 16'h7FFF,
                    16'h8000};
        1: regs = '{16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000,
                    16'h7FFF};
        2: begin
          // largest divisor; upper bit of the 15-bit registers set and ignored
          regs[0] = 16'hFFFF;
          regs[5] = 16'hFFFF;
          regs[6] = 16'hFFFF;
          regs[1] = 16'($urandom);
          regs[2] = 16'($urandom);
          regs[3] = 16'($urandom);
          regs[4] = 16'($urandom);
          regs[7] = 16'($urandom);
        end
        default: begin
          regs[0] = $urandom_range(0, 1) ? 16'($urandom_range(0, 200)) : 16'($urandom);
          for (int i = 1; i <= 7; i++)
            regs[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 4000) - 2000);
          regs[5] = $urandom_range(0, 1) ? 16'($urandom_range(1, 2000)) : 16'($urandom);
          regs[6] = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom);
        end
      endcase
      program_gains(regs);

      // some phases run with no idling; the last one always does
      idle_on = (ph % 3 != 2) && (ph != PHASES - 1);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 40)
          hold_req = ~hold_req;
        // sender pause until everything is back
        if (ph == 4 && n == 60)
          wait_drained;

        sel = int'($urandom_range(0, 99));
        if (sel < 70)
          enc = last_enc_sent + $urandom_range(0, 60) - 30;
        else if (sel < 85)
          enc = last_enc_sent + $urandom_range(0, 80000) - 40000;
        else if (sel < 95)
          enc = $urandom;
        else
          enc = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if ($urandom_range(0, 9) < 6)
          sp = 16'($urandom_range(0, 120) - 60);
        else
          sp = 16'($urandom);
        send_tick(enc, sp, 1'($urandom_range(0, 1)));
      end
    end

    wait_drained;
    // allow a stray extra result to show up
    repeat (60) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
